FILE: sv/imta_pkg.sv
package imta_pkg;

    localparam int COORD_W    = 32;
    localparam int IDX_W      = 16;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 13;
    localparam int CORNER_W   = 2;
    localparam int ERR_W      = 2;
    localparam int VCOUNT_W   = 13;
    localparam int TLIMIT_W   = 14;
    localparam int STEP_W     = 3;

    localparam int IN_DATA_W  = 3 * COORD_W + 4 * IDX_W;
    localparam int IN_USER_W  = OP_W + 1;
    localparam int OUT_FLD_W  = 3 * COORD_W + SLOT_W + CORNER_W + ERR_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;
    localparam int OUT_USER_W = KIND_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_VERTEX = 2'd0;
    localparam logic [OP_W-1:0] OP_FACE   = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [KIND_W-1:0] KIND_CORNER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CENTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INDEX = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    localparam logic REG_VERTEX_COUNT   = 1'b0;
    localparam logic REG_TRIANGLE_LIMIT = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec3_t;

endpackage

FILE: sv/indexed_mesh_triangle_assembler.sv
// Indexed triangle assembler. Vertex beats are written into a single-port-read vertex
// memory (VERTEX_DEPTH entries, contents undefined until written, no clearing pass after
// reset) and widen the bounding box; face beats are expanded into three triangle corners,
// or six for a quad, each read from that memory and tagged with its slot; a finish beat
// returns the box centre. A vertex, finish or unknown beat is a single step; a face is one
// step per corner (3 or 6), or fewer when it ends in an error result, since the memory gives
// one corner per cycle while the output register is free. Results are registered the cycle
// after issue; the next beat is taken in the cycle the current one issues its final step.
module indexed_mesh_triangle_assembler #(
    parameter int VERTEX_DEPTH   = 4096,
    parameter int TRIANGLE_SLOTS = 8192
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pos_x, pos_y, pos_z, idx_a, idx_b, idx_c, idx_d
    input  logic [imta_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // opcode, is_quad
    input  logic [imta_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_x, out_y, out_z, tri_slot, corner, error_code, zero pad
    output logic [imta_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // kind
    output logic [imta_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [imta_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [imta_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [imta_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    import imta_pkg::*;

    localparam int AW    = $clog2(VERTEX_DEPTH);
    localparam int VN_W  = $clog2(VERTEX_DEPTH + 1);
    localparam int LIM_W = (VN_W > IDX_W) ? VN_W : IDX_W;
    localparam int TN_W  = $clog2(TRIANGLE_SLOTS + 1);
    localparam int TL_W  = (TN_W > TLIMIT_W) ? TN_W : TLIMIT_W;

    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(VERTEX_DEPTH);
    localparam logic [VN_W-1:0]  DEPTH_V = VN_W'(VERTEX_DEPTH);
    localparam logic [TL_W-1:0]  SLOTS_L = TL_W'(TRIANGLE_SLOTS);

    localparam logic [STEP_W-1:0] STEP_T1A = 3'd0;
    localparam logic [STEP_W-1:0] STEP_T1B = 3'd1;
    localparam logic [STEP_W-1:0] STEP_T1C = 3'd2;
    localparam logic [STEP_W-1:0] STEP_T2C = 3'd3;
    localparam logic [STEP_W-1:0] STEP_T2D = 3'd4;
    localparam logic [STEP_W-1:0] STEP_T2A = 3'd5;

    logic [VCOUNT_W-1:0] vertex_count_reg;
    logic [TLIMIT_W-1:0] triangle_limit_reg;
    logic [VN_W-1:0]     vertex_next_reg;
    logic [TN_W-1:0]     triangle_next_reg;
    vec3_t               box_min_reg;
    vec3_t               box_max_reg;

    logic                cur_valid_reg;
    logic [OP_W-1:0]     cur_op_reg;
    vec3_t               cur_pos_reg;
    logic [IDX_W-1:0]    cur_a_reg;
    logic [IDX_W-1:0]    cur_b_reg;
    logic [IDX_W-1:0]    cur_c_reg;
    logic [IDX_W-1:0]    cur_d_reg;
    logic                cur_quad_reg;
    logic [STEP_W-1:0]   step_reg;

    logic                s1_valid_reg;
    logic                s1_from_ram_reg;
    logic [KIND_W-1:0]   s1_kind_reg;
    vec3_t               s1_pos_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [CORNER_W-1:0] s1_corner_reg;
    logic [ERR_W-1:0]    s1_err_reg;
    logic                s1_last_reg;

    logic [LIM_W-1:0]    lim_v;
    logic [TL_W-1:0]     lim_t;
    logic                full;
    logic                second;
    logic [IDX_W-1:0]    i0;
    logic [IDX_W-1:0]    i1;
    logic [IDX_W-1:0]    i2;
    logic [ERR_W-1:0]    err_sel;
    logic                face_err;
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    rd_m1;
    logic [CORNER_W-1:0] corner_num;
    logic                tri_end;
    logic                face_last;
    logic                is_face;
    logic                is_finish;
    logic                need_out;
    logic                out_free;
    logic                go;
    logic                done;
    logic                accept;
    logic                vertex_wr;
    logic                ram_re;
    logic                tn_inc;
    logic                cfg_wr;
    vec3_t               center;
    vec3_t               ram_rdata;
    vec3_t               out_pos;
    logic [TN_W+SLOT_W-1:0] tn_wide;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input logic [LIM_W-1:0] lim);
        return (idx != '0) && (LIM_W'(idx) <= lim);
    endfunction

    function automatic coord_t half_sum(input coord_t a, input coord_t b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    function automatic coord_t cmin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t cmax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == REG_TRIANGLE_LIMIT)
        begin
            prdata = APB_DATA_W'(triangle_limit_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(vertex_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg   <= '0;
            triangle_limit_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_VERTEX_COUNT)
            begin
                vertex_count_reg <= pwdata[VCOUNT_W-1:0];
            end
            else
            begin
                triangle_limit_reg <= pwdata[TLIMIT_W-1:0];
            end
        end
    end

    // face checks
    assign lim_v  = (LIM_W'(vertex_count_reg) < DEPTH_L) ? LIM_W'(vertex_count_reg) : DEPTH_L;
    assign lim_t  = (TL_W'(triangle_limit_reg) < SLOTS_L) ? TL_W'(triangle_limit_reg) : SLOTS_L;
    assign full   = TL_W'(triangle_next_reg) >= lim_t;
    assign second = step_reg >= STEP_T2C;
    assign i0     = second ? cur_c_reg : cur_a_reg;
    assign i1     = second ? cur_d_reg : cur_b_reg;
    assign i2     = second ? cur_a_reg : cur_c_reg;

    always_comb
    begin
        if (!idx_ok(i0, lim_v))
        begin
            err_sel = ERR_INDEX;
        end
        else if (full)
        begin
            err_sel = ERR_FULL;
        end
        else if (!idx_ok(i1, lim_v) || !idx_ok(i2, lim_v))
        begin
            err_sel = ERR_INDEX;
        end
        else
        begin
            err_sel = ERR_NONE;
        end
    end

    assign face_err = ((step_reg == STEP_T1A) || (step_reg == STEP_T2C)) && (err_sel != ERR_NONE);

    always_comb
    begin
        case (step_reg)
            STEP_T1A:
            begin
                rd_idx     = cur_a_reg;
                corner_num = 2'd0;
            end
            STEP_T1B:
            begin
                rd_idx     = cur_b_reg;
                corner_num = 2'd1;
            end
            STEP_T1C:
            begin
                rd_idx     = cur_c_reg;
                corner_num = 2'd2;
            end
            STEP_T2C:
            begin
                rd_idx     = cur_c_reg;
                corner_num = 2'd0;
            end
            STEP_T2D:
            begin
                rd_idx     = cur_d_reg;
                corner_num = 2'd1;
            end
            STEP_T2A:
            begin
                rd_idx     = cur_a_reg;
                corner_num = 2'd2;
            end
            default:
            begin
                rd_idx     = cur_a_reg;
                corner_num = 2'd0;
            end
        endcase
    end

    assign rd_m1     = rd_idx - IDX_W'(1);
    assign tri_end   = (step_reg == STEP_T1C) || (step_reg == STEP_T2A);
    assign face_last = face_err || ((step_reg == STEP_T1C) && !cur_quad_reg)
                       || (step_reg == STEP_T2A);

    // issue control
    assign is_face   = cur_op_reg == OP_FACE;
    assign is_finish = cur_op_reg == OP_FINISH;
    assign need_out  = is_face || is_finish;
    assign out_free  = !s1_valid_reg || m_axis_tready;
    assign go        = cur_valid_reg && (out_free || !need_out);
    assign done      = go && (!is_face || face_last);

    assign s_axis_tready = !cur_valid_reg || done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign vertex_wr = go && (cur_op_reg == OP_VERTEX) && (vertex_next_reg != DEPTH_V);
    assign ram_re    = go && is_face && !face_err;
    assign tn_inc    = ram_re && tri_end;

    assign center.x = half_sum(box_min_reg.x, box_max_reg.x);
    assign center.y = half_sum(box_min_reg.y, box_max_reg.y);
    assign center.z = half_sum(box_min_reg.z, box_max_reg.z);

    assign tn_wide = {{SLOT_W{1'b0}}, triangle_next_reg};

    imta_ram #(
        .WIDTH ($bits(vec3_t)),
        .DEPTH (VERTEX_DEPTH)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (vertex_wr),
        .waddr (vertex_next_reg[AW-1:0]),
        .wdata (cur_pos_reg),
        .re    (ram_re),
        .raddr (rd_m1[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg     <= 1'b0;
            step_reg          <= STEP_T1A;
            vertex_next_reg   <= '0;
            triangle_next_reg <= '0;
            box_min_reg       <= '0;
            box_max_reg       <= '0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= STEP_T1A;
            end
            else if (done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (go)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end

            if (vertex_wr)
            begin
                vertex_next_reg <= vertex_next_reg + VN_W'(1);
                if (vertex_next_reg == '0)
                begin
                    box_min_reg <= cur_pos_reg;
                    box_max_reg <= cur_pos_reg;
                end
                else
                begin
                    box_min_reg.x <= cmin(box_min_reg.x, cur_pos_reg.x);
                    box_min_reg.y <= cmin(box_min_reg.y, cur_pos_reg.y);
                    box_min_reg.z <= cmin(box_min_reg.z, cur_pos_reg.z);
                    box_max_reg.x <= cmax(box_max_reg.x, cur_pos_reg.x);
                    box_max_reg.y <= cmax(box_max_reg.y, cur_pos_reg.y);
                    box_max_reg.z <= cmax(box_max_reg.z, cur_pos_reg.z);
                end
            end

            if (tn_inc)
            begin
                triangle_next_reg <= triangle_next_reg + TN_W'(1);
            end

            if (out_free)
            begin
                s1_valid_reg <= go && need_out;
            end
        end
    end

    // hold the current beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_op_reg    <= s_axis_tuser[OP_W-1:0];
            cur_quad_reg  <= s_axis_tuser[OP_W];
            cur_pos_reg.x <= s_axis_tdata[COORD_W-1:0];
            cur_pos_reg.y <= s_axis_tdata[2*COORD_W-1:COORD_W];
            cur_pos_reg.z <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
            cur_a_reg     <= s_axis_tdata[3*COORD_W+IDX_W-1:3*COORD_W];
            cur_b_reg     <= s_axis_tdata[3*COORD_W+2*IDX_W-1:3*COORD_W+IDX_W];
            cur_c_reg     <= s_axis_tdata[3*COORD_W+3*IDX_W-1:3*COORD_W+2*IDX_W];
            cur_d_reg     <= s_axis_tdata[3*COORD_W+4*IDX_W-1:3*COORD_W+3*IDX_W];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_free && go && need_out)
        begin
            if (is_finish)
            begin
                s1_kind_reg     <= KIND_CENTER;
                s1_from_ram_reg <= 1'b0;
                s1_pos_reg      <= center;
                s1_slot_reg     <= '0;
                s1_corner_reg   <= '0;
                s1_err_reg      <= ERR_NONE;
                s1_last_reg     <= 1'b1;
            end
            else if (face_err)
            begin
                s1_kind_reg     <= KIND_ERROR;
                s1_from_ram_reg <= 1'b0;
                s1_pos_reg      <= '0;
                s1_slot_reg     <= '0;
                s1_corner_reg   <= '0;
                s1_err_reg      <= err_sel;
                s1_last_reg     <= 1'b1;
            end
            else
            begin
                s1_kind_reg     <= KIND_CORNER;
                s1_from_ram_reg <= 1'b1;
                s1_pos_reg      <= '0;
                s1_slot_reg     <= tn_wide[SLOT_W-1:0];
                s1_corner_reg   <= corner_num;
                s1_err_reg      <= ERR_NONE;
                s1_last_reg     <= face_last;
            end
        end
    end

    assign out_pos       = s1_from_ram_reg ? ram_rdata : s1_pos_reg;
    assign m_axis_tvalid = s1_valid_reg;
    assign m_axis_tuser  = s1_kind_reg;
    assign m_axis_tlast  = s1_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, s1_err_reg, s1_corner_reg, s1_slot_reg,
                            out_pos.z, out_pos.y, out_pos.x};

endmodule

FILE: sv/imta_ram.sv
module imta_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
